/* rtl/core/mhpq_pkg.sv */
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants of the max-heap priority queue: field widths,
// register map, and the command and status bundles that link the
// controller with the datapath.
// ----------------------------------------------------------------------------
package mhpq_pkg;

  localparam int VALUE_W          = 32;
  localparam int COUNT_W          = 8;
  localparam int CAP_W            = 8;
  localparam int DEFAULT_CAPACITY = 100;
  localparam int MAX_ENTRIES_DEF  = 128;

  // Configuration port.
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam logic [APB_AW-3:0] REG_CAPACITY = '0;

  // Operation codes of the input item.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_START,
    CMD_RD_PARENT,
    CMD_INS_MOVE,
    CMD_INS_FINAL,
    CMD_RD_LAST,
    CMD_LOAD_MOVING,
    CMD_RD_CHILD,
    CMD_REM_MOVE,
    CMD_REM_FINAL,
    CMD_RD_REPORT,
    CMD_LOAD_OUT
  } dp_cmd_e;

  typedef struct packed {
    logic start_remove;  // the offered item is a remove
    logic start_err;     // the offered item would fail
    logic ins_root;      // the insert slot is the root
    logic ins_stop;      // the parent is not smaller than the new value
    logic rem_leaf;      // the moving entry has no child
    logic rem_stop;      // the moving entry beats the larger child
  } dp_status_t;

endpackage

/* rtl/core/mhpq_ctrl.sv */
// ----------------------------------------------------------------------------
// mhpq_ctrl
// Sequencer of the heap queue. Walks an insert up or a remove down the
// heap one level at a time, a read state and then a compare state per level,
// and hands the finished result to the output register.
// ----------------------------------------------------------------------------
module mhpq_ctrl
  import mhpq_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  dp_status_t status_i,
  output dp_cmd_e    cmd_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_CHECK,
    S_INS_CMP,
    S_REM_LAST,
    S_REM_LOAD,
    S_REM_CHECK,
    S_REM_CMP,
    S_RD_REPORT,
    S_REPORT
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cmd_o       = CMD_NONE;
    out_valid_d = out_valid_q && !out_ready_i;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o = CMD_START;
          if (status_i.start_err) begin
            state_d = S_RD_REPORT;
          end else if (status_i.start_remove) begin
            state_d = S_REM_LAST;
          end else begin
            state_d = S_INS_CHECK;
          end
        end
      end
      S_INS_CHECK: begin
        if (status_i.ins_root) begin
          cmd_o   = CMD_INS_FINAL;
          state_d = S_RD_REPORT;
        end else begin
          cmd_o   = CMD_RD_PARENT;
          state_d = S_INS_CMP;
        end
      end
      S_INS_CMP: begin
        if (status_i.ins_stop) begin
          cmd_o   = CMD_INS_FINAL;
          state_d = S_RD_REPORT;
        end else begin
          cmd_o   = CMD_INS_MOVE;
          state_d = S_INS_CHECK;
        end
      end
      S_REM_LAST: begin
        cmd_o   = CMD_RD_LAST;
        state_d = S_REM_LOAD;
      end
      S_REM_LOAD: begin
        cmd_o   = CMD_LOAD_MOVING;
        state_d = S_REM_CHECK;
      end
      S_REM_CHECK: begin
        if (status_i.rem_leaf) begin
          cmd_o   = CMD_REM_FINAL;
          state_d = S_RD_REPORT;
        end else begin
          cmd_o   = CMD_RD_CHILD;
          state_d = S_REM_CMP;
        end
      end
      S_REM_CMP: begin
        if (status_i.rem_stop) begin
          cmd_o   = CMD_REM_FINAL;
          state_d = S_RD_REPORT;
        end else begin
          cmd_o   = CMD_REM_MOVE;
          state_d = S_REM_CHECK;
        end
      end
      S_RD_REPORT: begin
        cmd_o   = CMD_RD_REPORT;
        state_d = S_REPORT;
      end
      S_REPORT: begin
        // Wait here while an earlier result is still unclaimed.
        if (out_free) begin
          cmd_o       = CMD_LOAD_OUT;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

/* rtl/core/mhpq_dp.sv */
// ----------------------------------------------------------------------------
// mhpq_dp
// Datapath of the heap queue: heap memory with one write and two read
// ports, occupancy count, the sift registers and the result register.
// ----------------------------------------------------------------------------
module mhpq_dp
  import mhpq_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  dp_cmd_e            cmd_i,
  input  logic               operation_i,
  input  logic [VALUE_W-1:0] value_i,
  input  logic [CAP_W-1:0]   capacity_i,
  output dp_status_t         status_o,
  output logic [VALUE_W-1:0] top_value_o,
  output logic [VALUE_W-1:0] last_value_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic               is_empty_o,
  output logic               is_full_o,
  output logic               op_error_o
);

  localparam int ADDR_W = $clog2(MAX_ENTRIES);
  localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
  localparam int EW     = CNT_W + CAP_W;
  localparam int CW     = ADDR_W + 2;

  logic [VALUE_W-1:0] mem_q [MAX_ENTRIES];
  logic [VALUE_W-1:0] rd_a_q, rd_b_q, val_q;
  logic [ADDR_W-1:0]  pos_q, pos_d;
  logic [CNT_W-1:0]   occ_q, occ_d, occ_m1;
  logic               err_q, err_d;

  logic [EW-1:0]      cap_eff, cap_raw;
  logic               full_now, start_err;
  logic [ADDR_W-1:0]  parent;
  logic [CW-1:0]      left_idx, right_idx, occ_ext;
  logic               right_ok, pick_right;
  logic [VALUE_W-1:0] chosen;
  logic [ADDR_W-1:0]  chosen_idx;

  logic               we, rd_en;
  logic [ADDR_W-1:0]  waddr, raddr_a, raddr_b;
  logic [VALUE_W-1:0] wdata;

  logic [VALUE_W-1:0] top_q, last_q;
  logic [COUNT_W-1:0] count_q;
  logic               empty_q, full_q, err_out_q;

  // A capacity of zero falls back to the default; both are capped by depth.
  always_comb begin
    cap_raw = (capacity_i == '0) ? EW'(DEFAULT_CAPACITY) : EW'(capacity_i);
    cap_eff = (cap_raw > EW'(MAX_ENTRIES)) ? EW'(MAX_ENTRIES) : cap_raw;
  end

  assign full_now  = (EW'(occ_q) >= cap_eff);
  assign start_err = (operation_i == OP_REMOVE) ? (occ_q == '0) : full_now;
  assign occ_m1    = occ_q - CNT_W'(1);

  assign parent    = (pos_q - ADDR_W'(1)) >> 1;
  assign left_idx  = CW'({pos_q, 1'b1});
  assign right_idx = left_idx + CW'(1);
  assign occ_ext   = CW'(occ_q);
  assign right_ok  = (right_idx < occ_ext);

  // The right child wins only when it is strictly larger.
  assign pick_right = right_ok && ($signed(rd_a_q) < $signed(rd_b_q));
  assign chosen     = pick_right ? rd_b_q : rd_a_q;
  assign chosen_idx = pick_right ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];

  always_comb begin
    status_o.start_remove = (operation_i == OP_REMOVE);
    status_o.start_err    = start_err;
    status_o.ins_root     = (pos_q == '0);
    status_o.ins_stop     = ($signed(rd_a_q) >= $signed(val_q));
    status_o.rem_leaf     = (left_idx >= occ_ext);
    status_o.rem_stop     = ($signed(val_q) > $signed(chosen));
  end

  always_comb begin
    we      = 1'b0;
    rd_en   = 1'b0;
    waddr   = pos_q;
    wdata   = val_q;
    raddr_a = '0;
    raddr_b = '0;
    pos_d   = pos_q;
    occ_d   = occ_q;
    err_d   = err_q;
    case (cmd_i)
      CMD_START: begin
        err_d = start_err;
        if (!start_err) begin
          if (operation_i == OP_REMOVE) begin
            occ_d = occ_m1;
            pos_d = '0;
          end else begin
            occ_d = occ_q + CNT_W'(1);
            pos_d = occ_q[ADDR_W-1:0];
          end
        end
      end
      CMD_RD_PARENT: begin
        rd_en   = 1'b1;
        raddr_a = parent;
      end
      CMD_INS_MOVE: begin
        we    = 1'b1;
        wdata = rd_a_q;
        pos_d = parent;
      end
      CMD_INS_FINAL, CMD_REM_FINAL: begin
        we = 1'b1;
      end
      CMD_RD_LAST: begin
        // Occupancy is already decremented and names the old last slot.
        rd_en   = 1'b1;
        raddr_a = occ_q[ADDR_W-1:0];
      end
      CMD_RD_CHILD: begin
        rd_en   = 1'b1;
        raddr_a = left_idx[ADDR_W-1:0];
        raddr_b = right_ok ? right_idx[ADDR_W-1:0] : left_idx[ADDR_W-1:0];
      end
      CMD_REM_MOVE: begin
        we    = 1'b1;
        wdata = chosen;
        pos_d = chosen_idx;
      end
      CMD_RD_REPORT: begin
        rd_en   = 1'b1;
        raddr_b = (occ_q == '0) ? '0 : occ_m1[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rd_a_q <= mem_q[raddr_a];
      rd_b_q <= mem_q[raddr_b];
    end
    if (cmd_i == CMD_START) begin
      val_q <= value_i;
    end else if (cmd_i == CMD_LOAD_MOVING) begin
      val_q <= rd_a_q;
    end
    pos_q <= pos_d;
    if (cmd_i == CMD_LOAD_OUT) begin
      top_q     <= (occ_q == '0) ? '0 : rd_a_q;
      last_q    <= (occ_q == '0) ? '0 : rd_b_q;
      count_q   <= COUNT_W'(occ_q);
      empty_q   <= (occ_q == '0);
      full_q    <= full_now;
      err_out_q <= err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= '0;
      err_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
      err_q <= err_d;
    end
  end

  assign top_value_o   = top_q;
  assign last_value_o  = last_q;
  assign entry_count_o = count_q;
  assign is_empty_o    = empty_q;
  assign is_full_o     = full_q;
  assign op_error_o    = err_out_q;

endmodule

/* rtl/core/max_heap_priority_queue.sv */
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Binary max-heap priority queue of signed values with an APB capacity
// register, one result per item.
// ----------------------------------------------------------------------------
// Each item inserts a value or removes the largest entry, and is answered by
// one result with the new top entry, the entry in the last slot, the count
// and the empty, full and error flags. Items are handled one at a time; a
// result waits in an output register while the next item is accepted. An
// item moves its value up or down the heap one level at a time; each
// level costs a read step, which reads the parent or both children
// through the two read ports of the heap memory, and a step that
// compares and writes one slot. A remove first fetches the last entry,
// and every item ends by reading and loading the result. The next item
// is accepted in the cycle after the result is loaded, and loading waits
// as long as the previous result is unclaimed. The capacity register sits
// at byte address 0; a capacity of zero means 100, and any capacity is
// capped at MAX_ENTRIES. Failed inserts and removes leave the heap
// unchanged and set op_error_o.
module max_heap_priority_queue
  import mhpq_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              operation_i,
  input  logic [VALUE_W-1:0] value_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [VALUE_W-1:0] top_value_o,
  output logic [VALUE_W-1:0] last_value_o,
  output logic [COUNT_W-1:0] entry_count_o,
  output logic              is_empty_o,
  output logic              is_full_o,
  output logic              op_error_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  logic [CAP_W-1:0] capacity_q;
  logic             reg_sel_cap;
  dp_cmd_e          cmd;
  dp_status_t       status;

  assign pready      = 1'b1;
  assign reg_sel_cap = (paddr[APB_AW-1:2] == REG_CAPACITY);
  assign prdata      = reg_sel_cap ? APB_DW'(capacity_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q <= CAP_W'(DEFAULT_CAPACITY);
    end else if (psel && penable && pwrite && pready && reg_sel_cap) begin
      capacity_q <= pwdata[CAP_W-1:0];
    end
  end

  mhpq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mhpq_dp #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .capacity_i    (capacity_q),
    .status_o      (status),
    .top_value_o   (top_value_o),
    .last_value_o  (last_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .op_error_o    (op_error_o)
  );

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the max-heap priority queue: a heap predictor
// tracks every accepted item and checks each result in order.
// ----------------------------------------------------------------------------
// A short directed run covers removes on an empty queue, extreme and tied
// values, a full queue and a capacity lowered under the current occupancy.
// Random phases then sweep the capacity register through its extremes,
// with fill, drain and mixed stretches of items under varying back-pressure.
// ----------------------------------------------------------------------------

import mhpq_pkg::*;

typedef struct packed {
  logic [VALUE_W-1:0] top_v;
  logic [VALUE_W-1:0] last_v;
  logic [COUNT_W-1:0] count;
  logic               empty;
  logic               full;
  logic               err;
} heap_status_t;

class heap_scoreboard;
  localparam int HEAP_DEPTH = MAX_ENTRIES_DEF;

  logic signed [VALUE_W-1:0] slots[HEAP_DEPTH];
  int unsigned               held;
  logic [CAP_W-1:0]          cap_reg;
  heap_status_t              status_queue[$];
  int                        failures;

  function new();
    held     = 0;
    cap_reg  = CAP_W'(DEFAULT_CAPACITY);
    failures = 0;
  endfunction

  function void set_capacity(logic [CAP_W-1:0] cap);
    cap_reg = cap;
  endfunction

  function int unsigned capacity_limit();
    int unsigned lim;
    lim = (cap_reg == 0) ? DEFAULT_CAPACITY : cap_reg;
    if (lim > HEAP_DEPTH) lim = HEAP_DEPTH;
    return lim;
  endfunction

  // Applies one accepted item to the heap and queues the status it implies.
  function void note_item(logic op, logic signed [VALUE_W-1:0] v);
    int unsigned               lim;
    int unsigned               pos;
    int unsigned               parent;
    int unsigned               child;
    logic signed [VALUE_W-1:0] moving;
    heap_status_t              st;
    lim    = capacity_limit();
    st.err = 1'b0;
    if (op == OP_INSERT) begin
      if (held >= lim) begin
        st.err = 1'b1;
      end else begin
        pos  = held;
        held = held + 1;
        while (pos > 0) begin
          parent = (pos - 1) / 2;
          if (slots[parent] >= v) break;
          slots[pos] = slots[parent];
          pos        = parent;
        end
        slots[pos] = v;
      end
    end else begin
      if (held == 0) begin
        st.err = 1'b1;
      end else begin
        held   = held - 1;
        moving = slots[held];
        pos    = 0;
        child  = 1;
        // The right child wins only when strictly larger; ties sink further.
        while (child < held) begin
          if (child + 1 < held && slots[child] < slots[child + 1]) child = child + 1;
          if (moving > slots[child]) break;
          slots[pos] = slots[child];
          pos        = child;
          child      = 2 * pos + 1;
        end
        slots[pos] = moving;
      end
    end
    st.top_v  = (held == 0) ? '0 : slots[0];
    st.last_v = (held == 0) ? '0 : slots[held - 1];
    st.count  = COUNT_W'(held);
    st.empty  = (held == 0);
    st.full   = (held >= lim);
    status_queue.push_back(st);
  endfunction

  task report(string msg);
    if (failures < 40) $display("mismatch at %0t: %s", $time, msg);
    failures++;
  endtask

  task check_status(heap_status_t got);
    heap_status_t want;
    if (status_queue.size() == 0) begin
      report("result arrived with no item outstanding");
    end else begin
      want = status_queue.pop_front();
      if (got.top_v !== want.top_v)
        report($sformatf("top_value %0d, expected %0d",
                         $signed(got.top_v), $signed(want.top_v)));
      if (got.last_v !== want.last_v)
        report($sformatf("last_value %0d, expected %0d",
                         $signed(got.last_v), $signed(want.last_v)));
      if (got.count !== want.count)
        report($sformatf("entry_count %0d, expected %0d", got.count, want.count));
      if (got.empty !== want.empty)
        report($sformatf("is_empty %b, expected %b", got.empty, want.empty));
      if (got.full !== want.full)
        report($sformatf("is_full %b, expected %b", got.full, want.full));
      if (got.err !== want.err)
        report($sformatf("op_error %b, expected %b", got.err, want.err));
    end
  endtask
endclass

module tb;
  localparam int CYCLE_LIMIT  = 300000;
  localparam int PHASE_ITEMS  = 135;
  localparam int SETTLE_CYCLES = 40;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic               operation_i;
  logic [VALUE_W-1:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [VALUE_W-1:0] top_value_o;
  logic [VALUE_W-1:0] last_value_o;
  logic [COUNT_W-1:0] entry_count_o;
  logic               is_empty_o;
  logic               is_full_o;
  logic               op_error_o;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [APB_AW-1:0]  paddr;
  logic [APB_DW-1:0]  pwdata;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  heap_scoreboard sb = new();
  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int cap_plan[9] = '{0, 255, 128, 1, 2, 7, 200, 64, 100};

  max_heap_priority_queue uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .value_i       (value_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .top_value_o   (top_value_o),
    .last_value_o  (last_value_o),
    .entry_count_o (entry_count_o),
    .is_empty_o    (is_empty_o),
    .is_full_o     (is_full_o),
    .op_error_o    (op_error_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("tb NOT OK");
    $finish;
  end

  // Result side: sample before the edge updates, then pick the next stall.
  initial begin
    heap_status_t got;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && out_ready_i) begin
        got = '{top_value_o, last_value_o, entry_count_o,
                is_empty_o, is_full_o, op_error_o};
        sb.check_status(got);
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task send_item(input logic op, input logic [VALUE_W-1:0] v);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    value_i     <= v;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_item(op, v);
  endtask

  // Stops the item stream and waits for every outstanding result.
  task drain_results();
    in_valid_i <= 1'b0;
    while (sb.status_queue.size() != 0) @(posedge clk_i);
  endtask

  task write_capacity(input logic [CAP_W-1:0] cap);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CAPACITY, 2'b00};
    pwdata  <= APB_DW'(cap);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    sb.set_capacity(cap);
  endtask

  // Stretches of mostly inserts, mostly removes or an even mix, so that the
  // queue swings between empty and full; the first stretch is always mostly inserts.
  task run_random(input int n_items);
    int               done;
    int               chunk;
    int               ins_pct;
    bit               first;
    logic             op;
    logic [VALUE_W-1:0] v;
    done  = 0;
    first = 1'b1;
    while (done < n_items) begin
      chunk = $urandom_range(10, 100);
      case (first ? 0 : $urandom_range(0, 2))
        0: begin
          ins_pct = 90;
        end
        1: begin
          ins_pct = 10;
        end
        default: begin
          ins_pct = 50;
        end
      endcase
      first = 1'b0;
      repeat (chunk) begin
        if (done < n_items) begin
          op = ($urandom_range(0, 99) < ins_pct) ? OP_INSERT : OP_REMOVE;
          case ($urandom_range(0, 3))
            0: begin
              v = $urandom_range(0, 8) - 4;
            end
            1: begin
              case ($urandom_range(0, 3))
                0: v = 32'h8000_0000;
                1: v = 32'h7FFF_FFFF;
                2: v = '0;
                default: v = '1;
              endcase
            end
            default: begin
              v = $urandom;
            end
          endcase
          send_item(op, v);
          done++;
        end
      end
    end
  endtask

  initial begin
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    operation_i   <= OP_INSERT;
    value_i       <= '0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    send_idle_pct = 20;
    recv_idle_pct = 48;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset capacity.
    send_item(OP_REMOVE, 32'd123);
    send_item(OP_INSERT, 32'd0);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'h8000_0000);
    send_item(OP_INSERT, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 32'h7FFF_FFFF);
    send_item(OP_INSERT, 32'd5);
    send_item(OP_INSERT, 32'd5);
    repeat (7) send_item(OP_REMOVE, 32'hFFFF_FFFF);
    send_item(OP_REMOVE, 32'd0);
    drain_results();

    // A small capacity reaches full; then it is lowered under the occupancy.
    write_capacity(CAP_W'(3));
    send_item(OP_INSERT, 32'd1);
    send_item(OP_INSERT, 32'd2);
    send_item(OP_INSERT, 32'd3);
    send_item(OP_INSERT, 32'd4);
    drain_results();
    write_capacity(CAP_W'(1));
    send_item(OP_INSERT, 32'd9);
    send_item(OP_REMOVE, 32'd0);
    send_item(OP_INSERT, 32'd9);
    send_item(OP_REMOVE, 32'd0);
    drain_results();

    for (int i = 0; i < 9; i++) begin
      if (i < 3) begin
        send_idle_pct = 20;
        recv_idle_pct = 48;
      end else if (i < 6) begin
        send_idle_pct = 48;
        recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_capacity(CAP_W'(cap_plan[i]));
      run_random(PHASE_ITEMS);
      drain_results();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (sb.failures == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule
